// ===== src/surround_channel_downmix_top_macros.svh =====
// Assertion macros for the surround channel downmix block
`ifndef SURROUND_CHANNEL_DOWNMIX_TOP_MACROS_SVH
`define SURROUND_CHANNEL_DOWNMIX_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SCD_ASSERT_IMPL(lbl, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("scd: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define SCD_ASSERT_NEXT(lbl, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("scd: next-cycle check failed");

`endif

// ===== src/scd_pkg.sv =====
// Shared types, constants and mix matrix decode for the downmix block
`timescale 1ns / 1ps

package scd_pkg;

	localparam int NUM_IN       = 8;
	localparam int NUM_OUT      = 7;
	localparam int MIX_CHANNELS = 6;
	localparam int NUM_CELLS    = MIX_CHANNELS + 1;
	localparam int CENTRE_CH    = 2;
	localparam int COEF_W       = 17;
	localparam int ROUND_SHIFT  = 15;
	localparam int IN_CH_W      = 4;
	localparam int OUT_CH_W     = 3;
	localparam int CFG_DATA_W   = 4;
	localparam int CFG_IDX_W    = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_CHANNELS  = 1'b0,
		REG_OUT_CHANNELS = 1'b1
	} cfg_reg_t;

	typedef logic [2:0]        dest_t;
	typedef logic [COEF_W-1:0] coef_t;

	localparam dest_t NO_DEST = 3'd7;

	localparam coef_t C_ZERO  = 17'd0;
	localparam coef_t C_ONE   = 17'd32768;
	localparam coef_t C_R2    = 17'd23170;
	localparam coef_t C_HALF  = 17'd16384;
	localparam coef_t C_THIRD = 17'd10922;
	localparam coef_t C_QUART = 17'd8192;

	localparam logic [3:0] ROW_BASE [5] = '{4'd0, 4'd5, 4'd9, 4'd12, 4'd14};

	typedef struct packed {
		dest_t dest;
		coef_t coef;
	} cell_ctl_t;

	typedef struct packed {
		logic                          pass;
		cell_ctl_t [NUM_CELLS-1:0]     slot;
	} mix_ctl_t;

	// cell 6 carries the second centre contribution; lists run cell 6 down to cell 0
	function automatic mix_ctl_t mix_decode(input logic [IN_CH_W-1:0] nin,
		input logic [OUT_CH_W-1:0] nout);
		mix_ctl_t                  m;
		logic [IN_CH_W-1:0]        nmix;
		logic [3:0]                row;
		logic                      active;
		dest_t [NUM_CELLS-1:0]     d;
		coef_t [NUM_CELLS-1:0]     k;
		m      = '0;
		m.pass = (nout >= 3'd6) || ({1'b0, nout} >= nin);
		nmix   = (nin > IN_CH_W'(MIX_CHANNELS)) ? IN_CH_W'(MIX_CHANNELS) : nin;
		active = !m.pass;
		case (nout)
			3'd1: row = ROW_BASE[0] + nmix - 4'd2;
			3'd2: row = ROW_BASE[1] + nmix - 4'd3;
			3'd3: row = ROW_BASE[2] + nmix - 4'd4;
			3'd4: row = ROW_BASE[3] + nmix - 4'd5;
			3'd5: row = ROW_BASE[4] + nmix - 4'd6;
			default: begin
				row    = '0;
				active = 1'b0;
			end
		endcase
		d = {NUM_CELLS{NO_DEST}};
		k = '0;
		case (row)
			4'd0: begin
				d = {NO_DEST, NO_DEST, NO_DEST, NO_DEST, NO_DEST, 3'd0, 3'd0};
				k = {C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_HALF, C_HALF};
			end
			4'd1: begin
				d = {NO_DEST, NO_DEST, NO_DEST, NO_DEST, 3'd0, 3'd0, 3'd0};
				k = {C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_THIRD, C_THIRD, C_THIRD};
			end
			4'd2: begin
				d = {NO_DEST, NO_DEST, NO_DEST, 3'd0, 3'd0, 3'd0, 3'd0};
				k = {C_ZERO, C_ZERO, C_ZERO, C_QUART, C_QUART, C_QUART, C_QUART};
			end
			4'd3: begin
				d = {NO_DEST, NO_DEST, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
				k = {C_ZERO, C_ZERO, C_HALF, C_HALF, C_ONE, C_R2, C_R2};
			end
			4'd4: begin
				d = {NO_DEST, 3'd0, 3'd0, NO_DEST, 3'd0, 3'd0, 3'd0};
				k = {C_ZERO, C_HALF, C_HALF, C_ZERO, C_ONE, C_R2, C_R2};
			end
			4'd5: begin
				d = {3'd1, NO_DEST, NO_DEST, NO_DEST, 3'd0, 3'd1, 3'd0};
				k = {C_R2, C_ZERO, C_ZERO, C_ZERO, C_R2, C_ONE, C_ONE};
			end
			4'd6: begin
				d = {NO_DEST, NO_DEST, NO_DEST, 3'd1, 3'd0, 3'd1, 3'd0};
				k = {C_ZERO, C_ZERO, C_ZERO, C_HALF, C_HALF, C_HALF, C_HALF};
			end
			4'd7: begin
				d = {3'd1, NO_DEST, 3'd1, 3'd0, 3'd0, 3'd1, 3'd0};
				k = {C_R2, C_ZERO, C_R2, C_R2, C_R2, C_ONE, C_ONE};
			end
			4'd8: begin
				d = {3'd1, 3'd1, 3'd0, NO_DEST, 3'd0, 3'd1, 3'd0};
				k = {C_R2, C_R2, C_R2, C_ZERO, C_R2, C_ONE, C_ONE};
			end
			4'd9: begin
				d = {NO_DEST, NO_DEST, NO_DEST, 3'd1, 3'd0, 3'd1, 3'd0};
				k = {C_ZERO, C_ZERO, C_ZERO, C_QUART, C_QUART, C_QUART, C_QUART};
			end
			4'd10: begin
				d = {NO_DEST, NO_DEST, 3'd1, 3'd0, 3'd2, 3'd1, 3'd0};
				k = {C_ZERO, C_ZERO, C_HALF, C_HALF, C_ONE, C_HALF, C_HALF};
			end
			4'd11: begin
				d = {NO_DEST, 3'd1, 3'd0, NO_DEST, 3'd2, 3'd1, 3'd0};
				k = {C_ZERO, C_HALF, C_HALF, C_ZERO, C_ONE, C_HALF, C_HALF};
			end
			4'd12: begin
				d = {3'd1, NO_DEST, 3'd3, 3'd2, 3'd0, 3'd1, 3'd0};
				k = {C_R2, C_ZERO, C_ONE, C_ONE, C_R2, C_ONE, C_ONE};
			end
			4'd13: begin
				d = {3'd1, 3'd3, 3'd2, NO_DEST, 3'd0, 3'd1, 3'd0};
				k = {C_R2, C_ONE, C_ONE, C_ZERO, C_R2, C_ONE, C_ONE};
			end
			4'd14: begin
				d = {NO_DEST, 3'd4, 3'd3, NO_DEST, 3'd2, 3'd1, 3'd0};
				k = {C_ZERO, C_ONE, C_ONE, C_ZERO, C_ONE, C_ONE, C_ONE};
			end
			default: begin
				d = {NUM_CELLS{NO_DEST}};
				k = '0;
			end
		endcase
		if (!active) begin
			d = {NUM_CELLS{NO_DEST}};
			k = '0;
		end
		for (int i = 0; i < NUM_CELLS; i++) begin
			m.slot[i].dest = d[i];
			m.slot[i].coef = k[i];
		end
		return m;
	endfunction

endpackage

// ===== src/scd_cell.sv =====
// One multiply-accumulate cell of the downmix chain
`timescale 1ns / 1ps

module scd_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int ACC_W       = 21,
	parameter int SRC         = 0
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              load,
	input  logic                                              prev_valid,
	input  logic                                              prev_last,
	input  logic [scd_pkg::NUM_IN-1:0][SAMPLE_BITS-1:0]       prev_samples,
	input  logic [scd_pkg::NUM_OUT-1:0][ACC_W-1:0]            prev_acc,
	input  scd_pkg::cell_ctl_t                                ctl,
	output logic                                              cell_valid,
	output logic                                              cell_last,
	output logic [scd_pkg::NUM_IN-1:0][SAMPLE_BITS-1:0]       cell_samples,
	output logic [scd_pkg::NUM_OUT-1:0][ACC_W-1:0]            cell_acc
);
	import scd_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + COEF_W + 1;
	localparam int RND_W  = PROD_W - ROUND_SHIFT;
	localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(2 ** (ROUND_SHIFT - 1));

	logic signed [SAMPLE_BITS-1:0]      src;
	logic signed [PROD_W-1:0]           prod;
	logic signed [PROD_W-1:0]           prod_rnd;
	logic signed [RND_W-1:0]            term;
	logic [NUM_OUT-1:0][ACC_W-1:0]      acc_next;

	logic                               valid_q;
	logic                               last_q;
	logic [NUM_IN-1:0][SAMPLE_BITS-1:0] samples_q;
	logic [NUM_OUT-1:0][ACC_W-1:0]      acc_q;

	// round half up to Q1.15: add half an LSB, arithmetic shift
	always_comb begin
		src      = $signed(prev_samples[SRC]);
		prod     = $signed({1'b0, ctl.coef}) * src;
		prod_rnd = prod + HALF_LSB;
		term     = $signed(prod_rnd[PROD_W-1:ROUND_SHIFT]);
		acc_next = prev_acc;
		if (ctl.dest != NO_DEST) begin
			acc_next[ctl.dest] = ACC_W'($signed(prev_acc[ctl.dest]) + ACC_W'(term));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q    <= prev_last;
			samples_q <= prev_samples;
			acc_q     <= acc_next;
		end
	end

	assign cell_valid   = valid_q;
	assign cell_last    = last_q;
	assign cell_samples = samples_q;
	assign cell_acc     = acc_q;

endmodule

// ===== src/scd_out.sv =====
// Output stage: channel select, passthrough copy and saturation
`timescale 1ns / 1ps

module scd_out #(
	parameter int SAMPLE_BITS = 16,
	parameter int ACC_W       = 21
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              load,
	input  logic                                              prev_valid,
	input  logic                                              prev_last,
	input  logic [scd_pkg::NUM_IN-1:0][SAMPLE_BITS-1:0]       prev_samples,
	input  logic [scd_pkg::NUM_OUT-1:0][ACC_W-1:0]            prev_acc,
	input  logic                                              pass,
	input  logic [scd_pkg::IN_CH_W-1:0]                       in_channels,
	input  logic [scd_pkg::OUT_CH_W-1:0]                      out_channels,
	output logic                                              frame_valid,
	output logic                                              frame_last,
	output logic [scd_pkg::NUM_OUT-1:0][SAMPLE_BITS-1:0]      frame_samples
);
	import scd_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO =
		{{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

	logic [NUM_OUT-1:0][SAMPLE_BITS-1:0] sel;
	logic                                valid_q;
	logic                                last_q;
	logic [NUM_OUT-1:0][SAMPLE_BITS-1:0] samples_q;

	always_comb begin
		for (int c = 0; c < NUM_OUT; c++) begin
			sel[c] = '0;
			if (OUT_CH_W'(c) < out_channels) begin
				if (pass) begin
					if (IN_CH_W'(c) < in_channels) begin
						sel[c] = prev_samples[c];
					end
				end else if ($signed(prev_acc[c]) > SAT_HI) begin
					sel[c] = SAT_HI[SAMPLE_BITS-1:0];
				end else if ($signed(prev_acc[c]) < SAT_LO) begin
					sel[c] = SAT_LO[SAMPLE_BITS-1:0];
				end else begin
					sel[c] = prev_acc[c][SAMPLE_BITS-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q    <= prev_last;
			samples_q <= sel;
		end
	end

	assign frame_valid   = valid_q;
	assign frame_last    = last_q;
	assign frame_samples = samples_q;

endmodule

// ===== src/surround_channel_downmix_top.sv =====
// Top level of the surround channel downmix block
`timescale 1ns / 1ps

// Channel  Role     Handshake             Payload
// in       sink     in_valid / in_stall   sample_0 .. sample_7, frame_last
// out      source   out_valid / out_stall out_0 .. out_6, out_frame_last
// cfg      sink     cfg_we                cfg_index, cfg_data
//
// The pipeline is the input register, seven multiply-accumulate cells and the output register.
// One frame per cycle unless out stalls; each cell owns one 18x16 multiplier and one adder.
// Reset sets in_channels to 2, out_channels to 1 and empties every stage.
// A stall on out holds only full stages; empty stages behind it keep filling.

module surround_channel_downmix_top #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [scd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_BITS-1:0]        sample_0,
	input  logic signed [SAMPLE_BITS-1:0]        sample_1,
	input  logic signed [SAMPLE_BITS-1:0]        sample_2,
	input  logic signed [SAMPLE_BITS-1:0]        sample_3,
	input  logic signed [SAMPLE_BITS-1:0]        sample_4,
	input  logic signed [SAMPLE_BITS-1:0]        sample_5,
	input  logic signed [SAMPLE_BITS-1:0]        sample_6,
	input  logic signed [SAMPLE_BITS-1:0]        sample_7,
	input  logic                                 frame_last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_BITS-1:0]        out_0,
	output logic signed [SAMPLE_BITS-1:0]        out_1,
	output logic signed [SAMPLE_BITS-1:0]        out_2,
	output logic signed [SAMPLE_BITS-1:0]        out_3,
	output logic signed [SAMPLE_BITS-1:0]        out_4,
	output logic signed [SAMPLE_BITS-1:0]        out_5,
	output logic signed [SAMPLE_BITS-1:0]        out_6,
	output logic                                 out_frame_last
);
	import scd_pkg::*;

	`include "surround_channel_downmix_top_macros.svh"

	localparam int PROD_W = SAMPLE_BITS + COEF_W + 1;
	localparam int ACC_W  = PROD_W - ROUND_SHIFT + $clog2(NUM_CELLS);

	logic [IN_CH_W-1:0]                   in_channels_q;
	logic [OUT_CH_W-1:0]                  out_channels_q;
	mix_ctl_t                             ctl_q;

	logic                                 valid_s1;
	logic                                 last_s1;
	logic [NUM_IN-1:0][SAMPLE_BITS-1:0]   samples_s1;

	// index 0 is the input register, index k+1 is cell k
	logic [NUM_CELLS:0]                                   chain_valid;
	logic [NUM_CELLS:0]                                   chain_last;
	logic [NUM_CELLS:0][NUM_IN-1:0][SAMPLE_BITS-1:0]      chain_samples;
	logic [NUM_CELLS:0][NUM_OUT-1:0][ACC_W-1:0]           chain_acc;
	logic [NUM_CELLS+1:0]                                 ld;

	logic [NUM_OUT-1:0][SAMPLE_BITS-1:0]  frame_samples;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_channels_q  <= IN_CH_W'(2);
			out_channels_q <= OUT_CH_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IN_CHANNELS:  in_channels_q  <= cfg_data[IN_CH_W-1:0];
				REG_OUT_CHANNELS: out_channels_q <= cfg_data[OUT_CH_W-1:0];
				default: ;
			endcase
		end
	end

	// matrix decode, registered from the count registers and so following them in the next cycle
	always_ff @(posedge clk) begin
		ctl_q <= mix_decode(in_channels_q, out_channels_q);
	end

	always_comb begin
		ld[NUM_CELLS+1] = !out_valid || !out_stall;
		for (int j = NUM_CELLS; j >= 0; j--) begin
			ld[j] = !chain_valid[j] || ld[j+1];
		end
	end

	assign in_stall = !ld[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ld[0]) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			last_s1    <= frame_last;
			samples_s1 <= {sample_7, sample_6, sample_5, sample_4,
				sample_3, sample_2, sample_1, sample_0};
		end
	end

	assign chain_valid[0]   = valid_s1;
	assign chain_last[0]    = last_s1;
	assign chain_samples[0] = samples_s1;
	assign chain_acc[0]     = '0;

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		scd_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.ACC_W       (ACC_W),
			.SRC         ((k < MIX_CHANNELS) ? k : CENTRE_CH)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.load         (ld[k+1]),
			.prev_valid   (chain_valid[k]),
			.prev_last    (chain_last[k]),
			.prev_samples (chain_samples[k]),
			.prev_acc     (chain_acc[k]),
			.ctl          (ctl_q.slot[k]),
			.cell_valid   (chain_valid[k+1]),
			.cell_last    (chain_last[k+1]),
			.cell_samples (chain_samples[k+1]),
			.cell_acc     (chain_acc[k+1])
		);
	end

	scd_out #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.ACC_W       (ACC_W)
	) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (ld[NUM_CELLS+1]),
		.prev_valid    (chain_valid[NUM_CELLS]),
		.prev_last     (chain_last[NUM_CELLS]),
		.prev_samples  (chain_samples[NUM_CELLS]),
		.prev_acc      (chain_acc[NUM_CELLS]),
		.pass          (ctl_q.pass),
		.in_channels   (in_channels_q),
		.out_channels  (out_channels_q),
		.frame_valid   (out_valid),
		.frame_last    (out_frame_last),
		.frame_samples (frame_samples)
	);

	assign out_0 = $signed(frame_samples[0]);
	assign out_1 = $signed(frame_samples[1]);
	assign out_2 = $signed(frame_samples[2]);
	assign out_3 = $signed(frame_samples[3]);
	assign out_4 = $signed(frame_samples[4]);
	assign out_5 = $signed(frame_samples[5]);
	assign out_6 = $signed(frame_samples[6]);

	`SCD_ASSERT_IMPL(a_empty_out_never_stalls_in, !out_valid, !in_stall)
	`SCD_ASSERT_NEXT(a_accept_fills_input_reg, in_valid && !in_stall, chain_valid[0])
	`SCD_ASSERT_IMPL(a_unused_channel_zero, out_valid && (out_channels_q < 3'd3), out_2 == '0)
	`SCD_ASSERT_IMPL(a_downmix_tail_zero, out_valid && !ctl_q.pass, out_5 == '0 && out_6 == '0)

endmodule
